>>> src/utf8_sequence_checker_defines.svh
// assertion macros shared by the utf8 sequence checker files
`ifndef UTF8_SEQUENCE_CHECKER_DEFINES_SVH
`define UTF8_SEQUENCE_CHECKER_DEFINES_SVH

// same-cycle implication, sampled on clk, off while rst_n is low
`define UTF8SC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk, off while rst_n is low
`define UTF8SC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/utf8sc_pkg.sv
`default_nettype none

package utf8sc_pkg;

  // window geometry
  localparam int BYTE_W      = 8;
  localparam int WIN_BYTES   = 6;
  localparam int CNT_W       = 3;
  localparam int LEN_W       = 3;

  // stream widths
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 8;
  localparam int OUT_TUSER_W = 2;

  // result kind codes
  typedef enum logic [1:0] {
    KIND_EMPTY     = 2'd0,
    KIND_VALID     = 2'd1,
    KIND_INVALID   = 2'd2,
    KIND_TRUNCATED = 2'd3
  } result_kind_t;

  // one classification result
  typedef struct packed {
    result_kind_t     kind;
    logic [LEN_W-1:0] len;
  } utf8sc_result_t;

  typedef logic [WIN_BYTES-1:0][BYTE_W-1:0] window_t;

endpackage

`default_nettype wire

>>> src/utf8sc_classify.sv
`default_nettype none

module utf8sc_classify
  import utf8sc_pkg::*;
(
  input  window_t          win_i,
  input  logic [CNT_W-1:0] avail_i,
  output utf8sc_result_t   res_o
);

  logic [BYTE_W-1:0]    lead;
  logic [BYTE_W-1:0]    b1;
  logic [LEN_W-1:0]     seq_n;
  logic [CNT_W-1:0]     avail_sat;
  logic [WIN_BYTES-1:0] cont_ok;
  logic                 overlong;

  assign lead = win_i[0];
  assign b1   = win_i[1];

  // larger counts behave as a full window
  assign avail_sat = (avail_i > CNT_W'(WIN_BYTES)) ? CNT_W'(WIN_BYTES) : avail_i;

  // sequence length announced by the lead byte, zero for a stray or forbidden lead
  always_comb begin
    priority if (lead[7] == 1'b0)             seq_n = LEN_W'(1);
    else if (lead[7:5] == 3'b110)             seq_n = LEN_W'(2);
    else if (lead[7:4] == 4'b1110)            seq_n = LEN_W'(3);
    else if (lead[7:3] == 5'b11110)           seq_n = LEN_W'(4);
    else if (lead[7:2] == 6'b111110)          seq_n = LEN_W'(5);
    else if (lead[7:1] == 7'b1111110)         seq_n = LEN_W'(6);
    else                                      seq_n = LEN_W'(0);
  end

  // continuation pattern per byte, bytes past the sequence pass
  always_comb begin
    cont_ok[0] = 1'b1;
    for (int i = 1; i < WIN_BYTES; i++) begin
      cont_ok[i] = (LEN_W'(i) >= seq_n) || (win_i[i][7:6] == 2'b10);
    end
  end

  // overlong when the top code point bits that the length needs are all zero
  always_comb begin
    unique case (seq_n)
      LEN_W'(2): overlong = (lead[4:1] == 4'd0);
      LEN_W'(3): overlong = (lead[3:0] == 4'd0) && (b1[5] == 1'b0);
      LEN_W'(4): overlong = (lead[2:0] == 3'd0) && (b1[5:4] == 2'd0);
      LEN_W'(5): overlong = (lead[1:0] == 2'd0) && (b1[5:3] == 3'd0);
      LEN_W'(6): overlong = (lead[0] == 1'b0)   && (b1[5:2] == 4'd0);
      default:   overlong = 1'b0;
    endcase
  end

  // final classification, length check ahead of the byte checks
  always_comb begin
    priority if (avail_sat == CNT_W'(0)) begin
      res_o.kind = KIND_EMPTY;
      res_o.len  = LEN_W'(0);
    end else if (seq_n == LEN_W'(0)) begin
      res_o.kind = KIND_INVALID;
      res_o.len  = LEN_W'(1);
    end else if (seq_n == LEN_W'(1)) begin
      res_o.kind = KIND_VALID;
      res_o.len  = LEN_W'(1);
    end else if (avail_sat < seq_n) begin
      res_o.kind = KIND_TRUNCATED;
      res_o.len  = LEN_W'(0);
    end else begin
      res_o.kind = ((&cont_ok) && !overlong) ? KIND_VALID : KIND_INVALID;
      res_o.len  = seq_n;
    end
  end

endmodule

`default_nettype wire

>>> src/utf8_sequence_checker.sv
// UTF-8 sequence checker
//
// in channel: one six-byte window and a count of present bytes per item.
// out channel: the class of the sequence that starts at the first byte
// (empty, valid, invalid, truncated) in out_tuser and its length in
// out_tdata (valid: sequence length, invalid: bytes to skip, else 0).
// Lead bytes follow the original one- to six-byte forms.
//
// An item passes from the input register through the classification
// logic into the result register, where out_tvalid rises once the result
// register is free to take it. One item per cycle is taken while out_tready
// stays high. When the receiver stalls, the result register holds its item
// and the input register still takes one more item; in_tready drops only
// when both registers are full and out_tready is low.
// Reset (rst_n low, synchronous) empties both registers, which drives
// in_tready high.
`default_nettype none

module utf8_sequence_checker
  import utf8sc_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // in_tdata: byte_0[7:0], byte_1[15:8], byte_2[23:16], byte_3[31:24],
  //           byte_4[39:32], byte_5[47:40], avail_count[50:48], zero fill
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // out_tdata: seq_length[2:0], zero fill
  // out_tuser: result_kind[1:0]
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  output logic [OUT_TUSER_W-1:0]      out_tuser
);

  logic             s1_valid_r, s1_valid_nxt;
  window_t          s1_win_r;
  logic [CNT_W-1:0] s1_avail_r;
  logic             out_valid_r, out_valid_nxt;
  utf8sc_result_t   out_res_r;
  utf8sc_result_t   res;
  logic             out_ready;
  logic             s1_ready;
  logic             s1_take;
  logic             out_take;

  // stage handshakes
  assign out_ready = !out_valid_r || out_tready;
  assign s1_ready  = !s1_valid_r || out_ready;
  assign in_tready = s1_ready;
  assign s1_take   = in_tvalid && s1_ready;
  assign out_take  = s1_valid_r && out_ready;

  assign s1_valid_nxt  = s1_take ? 1'b1 : (out_take ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = out_take ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (s1_take) begin
      for (int i = 0; i < WIN_BYTES; i++) begin
        s1_win_r[i] <= in_tdata[i*BYTE_W +: BYTE_W];
      end
      s1_avail_r <= in_tdata[WIN_BYTES*BYTE_W +: CNT_W];
    end
  end

  utf8sc_classify u_classify (
    .win_i   (s1_win_r),
    .avail_i (s1_avail_r),
    .res_o   (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (out_take) begin
      out_res_r <= res;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W-LEN_W){1'b0}}, out_res_r.len};
  assign out_tuser  = out_res_r.kind;

endmodule

`default_nettype wire

>>> src/utf8sc_checker.sv
`default_nettype none

`include "utf8_sequence_checker_defines.svh"

module utf8sc_checker
  import utf8sc_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_tvalid,
  input wire logic                   in_tready,
  input wire logic [IN_TDATA_W-1:0]  in_tdata,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata,
  input wire logic [OUT_TUSER_W-1:0] out_tuser
);

  logic             in_seen;
  logic [LEN_W-1:0] out_len;
  logic             no_len_kind;

  assign in_seen     = in_tvalid && (in_tdata != '0);
  assign out_len     = out_tdata[LEN_W-1:0];
  assign no_len_kind = (out_tuser == KIND_EMPTY) || (out_tuser == KIND_TRUNCATED);

  // empty and truncated items carry no length
  `UTF8SC_ASSERT_NOW(a_no_len, out_tvalid && no_len_kind, out_len == LEN_W'(0), "len on empty or truncated")

  // valid and invalid items carry a length of one to six
  `UTF8SC_ASSERT_NOW(a_len_range, out_tvalid && !no_len_kind, (out_len != LEN_W'(0)) && (out_len <= LEN_W'(WIN_BYTES)), "length out of range")

  // a stalled result keeps its content
  `UTF8SC_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result changed")

  // input side only backs up behind a waiting result
  `UTF8SC_ASSERT_NOW(a_ready_path, !in_tready || (in_seen && !in_tready), out_tvalid && !out_tready, "input stalled without a waiting result")

endmodule

bind utf8_sequence_checker utf8sc_checker u_checker (.*);

`default_nettype wire

>>> tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
  import utf8sc_pkg::*;

  // one window waiting to be sent, with an optional pause for the pipe to drain
  typedef struct {
    logic [IN_TDATA_W-1:0] data;
    bit                    drain_first;
  } window_item_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [OUT_TUSER_W-1:0] out_tuser;

  window_item_t   window_queue[$];
  utf8sc_result_t expected_results[$];

  int  mismatch_count = 0;
  bit  in_taken = 1'b0;
  bit  out_taken = 1'b0;
  int  send_gap = 0;
  int  send_burst = 0;
  int  recv_stall = 0;
  int  recv_burst = 0;

  utf8_sequence_checker dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  // clock
  always #5 clk = ~clk;

  // expected class and length of the sequence at the start of a window
  function automatic utf8sc_result_t classify_window(input logic [IN_TDATA_W-1:0] item);
    logic [7:0]     b [WIN_BYTES];
    int unsigned    avail;
    int unsigned    n;
    logic [31:0]    cp;
    logic [31:0]    min_limit;
    bit             ok;
    utf8sc_result_t r;
    for (int i = 0; i < WIN_BYTES; i++) b[i] = item[8*i +: 8];
    avail = item[50:48];
    if (avail > WIN_BYTES) avail = WIN_BYTES;
    r.kind = KIND_EMPTY;
    r.len  = '0;
    if (avail != 0) begin
      casez (b[0])
        8'b0???????: n = 1;
        8'b110?????: n = 2;
        8'b1110????: n = 3;
        8'b11110???: n = 4;
        8'b111110??: n = 5;
        8'b1111110?: n = 6;
        default:     n = 0;
      endcase
      if (n == 0) begin
        r.kind = KIND_INVALID;
        r.len  = 3'd1;
      end else if (n == 1) begin
        r.kind = KIND_VALID;
        r.len  = 3'd1;
      end else if (avail < n) begin
        r.kind = KIND_TRUNCATED;
        r.len  = '0;
      end else begin
        // gather payload bits and check every continuation byte
        ok = 1'b1;
        cp = 32'(b[0] & (8'hFF >> (n + 1)));
        for (int i = 1; i < n; i++) begin
          if (b[i][7:6] != 2'b10) ok = 1'b0;
          cp = (cp << 6) | 32'(b[i][5:0]);
        end
        // largest code point that a shorter form could carry
        case (n)
          2:       min_limit = 32'h7F;
          3:       min_limit = 32'h7FF;
          4:       min_limit = 32'hFFFF;
          5:       min_limit = 32'h1FFFFF;
          default: min_limit = 32'h3FFFFFF;
        endcase
        if (cp <= min_limit) ok = 1'b0;
        r.kind = ok ? KIND_VALID : KIND_INVALID;
        r.len  = 3'(n);
      end
    end
    return r;
  endfunction

  function automatic logic [IN_TDATA_W-1:0] pack_window(
      input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2,
      input logic [7:0] b3, input logic [7:0] b4, input logic [7:0] b5,
      input int unsigned avail);
    return {5'b0, 3'(avail), b5, b4, b3, b2, b1, b0};
  endfunction

  // sequence of length n with random payload, optionally broken or cut short
  function automatic logic [IN_TDATA_W-1:0] random_sequence(
      input int unsigned n, input bit break_cont, input bit short_win);
    logic [7:0]  b [WIN_BYTES];
    logic [1:0]  top;
    int unsigned pos;
    int unsigned avail;
    for (int i = 0; i < WIN_BYTES; i++) b[i] = 8'($urandom);
    case (n)
      1:       b[0] = {1'b0, 7'($urandom)};
      2:       b[0] = {3'b110, 5'($urandom)};
      3:       b[0] = {4'b1110, 4'($urandom)};
      4:       b[0] = {5'b11110, 3'($urandom)};
      5:       b[0] = {6'b111110, 2'($urandom)};
      default: b[0] = {7'b1111110, 1'($urandom)};
    endcase
    // smallest lead payload now and then, to reach the overlong boundary
    if (n > 1 && $urandom_range(0, 9) == 0) b[0] = b[0] & ~(8'hFF >> (n + 1));
    for (int i = 1; i < n; i++) b[i] = {2'b10, 6'($urandom)};
    if (break_cont && n > 1) begin
      pos = $urandom_range(1, n - 1);
      top = 2'($urandom_range(0, 2));
      if (top == 2'b10) top = 2'b11;
      b[pos][7:6] = top;
    end
    if (short_win && n > 1) avail = $urandom_range(1, n - 1);
    else avail = $urandom_range(n, 7);
    return pack_window(b[0], b[1], b[2], b[3], b[4], b[5], avail);
  endfunction

  task automatic add_window(input logic [IN_TDATA_W-1:0] data, input bit drain_first);
    window_item_t w;
    w.data        = data;
    w.drain_first = drain_first;
    window_queue.push_back(w);
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatch_count < 40) $display("ERROR at %0t: %s", $realtime, msg);
    mismatch_count++;
  endtask

  // sender: one item at a time, random gap after each accepted item
  always @(negedge clk) begin
    logic                  nxt_valid;
    logic [IN_TDATA_W-1:0] nxt_data;
    nxt_valid = in_tvalid;
    nxt_data  = in_tdata;
    if (rst_n) begin
      if (in_tvalid && in_taken) begin
        nxt_valid = 1'b0;
        if (send_burst > 0) begin
          send_gap = 0;
          send_burst--;
        end else begin
          send_gap = $urandom_range(0, 10);
          if ($urandom_range(0, 39) == 0) send_burst = $urandom_range(20, 80);
        end
      end
      if (!nxt_valid) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (window_queue.size() > 0 &&
                     !(window_queue[0].drain_first && expected_results.size() != 0)) begin
          nxt_data  = window_queue[0].data;
          nxt_valid = 1'b1;
          void'(window_queue.pop_front());
        end
      end
    end
    in_tvalid <= nxt_valid;
    in_tdata  <= nxt_data;
  end

  // receiver: random stall after each accepted result
  always @(negedge clk) begin
    if (rst_n) begin
      if (out_taken) begin
        if (recv_burst > 0) begin
          recv_stall = 0;
          recv_burst--;
        end else begin
          recv_stall = $urandom_range(0, 10);
          if ($urandom_range(0, 39) == 0) recv_burst = $urandom_range(20, 80);
        end
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // monitor: predict on accepted input items, check accepted results
  always @(posedge clk) begin
    utf8sc_result_t want;
    if (!rst_n) begin
      in_taken  <= 1'b0;
      out_taken <= 1'b0;
    end else begin
      in_taken  <= in_tvalid && in_tready;
      out_taken <= out_tvalid && out_tready;
      if (out_tvalid && out_tready) begin
        if (expected_results.size() == 0) begin
          report_mismatch($sformatf("result with none expected: kind %0d len %0d",
                                    out_tuser, out_tdata[LEN_W-1:0]));
        end else begin
          want = expected_results.pop_front();
          if (out_tuser !== want.kind)
            report_mismatch($sformatf("result_kind got %0d want %0d", out_tuser, want.kind));
          if (out_tdata[LEN_W-1:0] !== want.len)
            report_mismatch($sformatf("seq_length got %0d want %0d",
                                      out_tdata[LEN_W-1:0], want.len));
        end
      end
      if (in_tvalid && in_tready) expected_results.push_back(classify_window(in_tdata));
    end
  end

  // stimulus and end of run
  initial begin
    int unsigned pick;
    // empty window and saturated count
    add_window(pack_window(8'hC2, 8'h80, 8'h41, 8'h42, 8'h43, 8'h44, 0), 1'b0);
    add_window(pack_window(8'h41, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 7), 1'b0);
    add_window(pack_window(8'hFD, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 7), 1'b0);
    // ascii leads
    add_window(pack_window(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 1), 1'b0);
    add_window(pack_window(8'h7F, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 6), 1'b0);
    // stray and forbidden leads
    add_window(pack_window(8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 6), 1'b0);
    add_window(pack_window(8'hBF, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 1), 1'b0);
    add_window(pack_window(8'hFE, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 6), 1'b0);
    add_window(pack_window(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 6), 1'b0);
    // two bytes: smallest, overlong, largest, bad continuation
    add_window(pack_window(8'hC2, 8'h80, 8'h00, 8'h00, 8'h00, 8'h00, 2), 1'b0);
    add_window(pack_window(8'hC1, 8'hBF, 8'h00, 8'h00, 8'h00, 8'h00, 2), 1'b0);
    add_window(pack_window(8'hDF, 8'hBF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 6), 1'b0);
    add_window(pack_window(8'hC2, 8'hC0, 8'h00, 8'h00, 8'h00, 8'h00, 2), 1'b0);
    // three bytes
    add_window(pack_window(8'hE0, 8'hA0, 8'h80, 8'h00, 8'h00, 8'h00, 3), 1'b0);
    add_window(pack_window(8'hE0, 8'h9F, 8'hBF, 8'h00, 8'h00, 8'h00, 3), 1'b0);
    add_window(pack_window(8'hE1, 8'h80, 8'h7F, 8'h00, 8'h00, 8'h00, 4), 1'b0);
    // four bytes
    add_window(pack_window(8'hF0, 8'h90, 8'h80, 8'h80, 8'h00, 8'h00, 4), 1'b0);
    add_window(pack_window(8'hF0, 8'h8F, 8'hBF, 8'hBF, 8'h00, 8'h00, 4), 1'b0);
    add_window(pack_window(8'hF7, 8'hBF, 8'hBF, 8'hBF, 8'h00, 8'h00, 5), 1'b0);
    // five and six bytes, valid and overlong
    add_window(pack_window(8'hF8, 8'h88, 8'h80, 8'h80, 8'h80, 8'h00, 5), 1'b0);
    add_window(pack_window(8'hF8, 8'h87, 8'hBF, 8'hBF, 8'hBF, 8'h00, 5), 1'b0);
    add_window(pack_window(8'hFC, 8'h84, 8'h80, 8'h80, 8'h80, 8'h80, 6), 1'b0);
    add_window(pack_window(8'hFC, 8'h83, 8'hBF, 8'hBF, 8'hBF, 8'hBF, 6), 1'b0);
    // short window wins over a bad present byte
    add_window(pack_window(8'hE0, 8'h00, 8'h80, 8'h00, 8'h00, 8'h00, 2), 1'b0);
    add_window(pack_window(8'hFC, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 5), 1'b0);
    // bytes past the sequence are ignored
    add_window(pack_window(8'hC2, 8'h80, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 6), 1'b0);

    // random part: mostly well-formed sequences, some broken, some noise
    for (int k = 0; k < 1800; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)
        add_window(random_sequence($urandom_range(1, 6), 1'b0, 1'b0), k == 0 || k == 900);
      else if (pick < 70)
        add_window(random_sequence($urandom_range(2, 6), 1'b1, 1'b0), k == 0 || k == 900);
      else if (pick < 85)
        add_window(random_sequence($urandom_range(2, 6), $urandom_range(0, 1), 1'b1),
                   k == 0 || k == 900);
      else
        add_window({5'b0, 3'($urandom_range(0, 7)), 16'($urandom), 32'($urandom)},
                   k == 0 || k == 900);
    end

    // reset
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // drain
    while (window_queue.size() != 0 || in_tvalid || expected_results.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
    if (expected_results.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", expected_results.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule
